[rtl/rpv_pkg.sv]
package rpv_pkg;

  localparam int ByteW     = 8;
  localparam int PathLenW  = 11;
  localparam int CompLenW  = 9;
  localparam int CompLimW  = 8;
  localparam int CompCntW  = 6;
  localparam int VerdictW  = 4;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 11;

  localparam logic [PathLenW-1:0] PATH_LEN_CAP   = 11'd1024;
  localparam logic [PathLenW-1:0] PATH_COUNT_MAX = 11'd2047;
  localparam logic [CompLenW-1:0] COMP_LEN_MAX   = 9'd511;
  localparam logic [CompLimW-1:0] COMP_LEN_RST   = 8'd255;
  localparam logic [CompCntW-1:0] COMP_CNT_RST   = 6'd32;

  localparam logic [ByteW-1:0] BYTE_LOW    = 8'h20;
  localparam logic [ByteW-1:0] BYTE_HIGH   = 8'h7e;
  localparam logic [ByteW-1:0] CHAR_SLASH  = 8'h2f;
  localparam logic [ByteW-1:0] CHAR_BSLASH = 8'h5c;
  localparam logic [ByteW-1:0] CHAR_DOT    = 8'h2e;
  localparam logic [ByteW-1:0] CHAR_SPACE  = 8'h20;

  typedef enum logic [VerdictW-1:0] {
    V_OK         = 4'd0,
    V_LENGTH     = 4'd1,
    V_ABSOLUTE   = 4'd2,
    V_BACKSLASH  = 4'd3,
    V_EMPTY      = 4'd4,
    V_LONG       = 4'd5,
    V_DOT        = 4'd6,
    V_DOTDOT     = 4'd7,
    V_LEAD_SPACE = 4'd8,
    V_TRAIL      = 4'd9,
    V_BYTE       = 4'd10,
    V_COUNT      = 4'd11
  } verdict_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_MAX_PATH_LEN = 2'd0,
    REG_MAX_COMP_LEN = 2'd1,
    REG_MAX_COMP_CNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PathLenW-1:0] max_path_len;
    logic [CompLimW-1:0] max_comp_len;
    logic [CompCntW-1:0] max_comp_cnt;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] path_byte;
    logic             is_last;
    logic             no_byte;
  } item_t;

endpackage

[rtl/rpv_cfg_regs.sv]
module rpv_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [rpv_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [rpv_pkg::CfgDataW-1:0]    cfg_wdata,
  output rpv_pkg::cfg_t                   cfg
);
  import rpv_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_path_len <= PATH_LEN_CAP;
      cfg_r.max_comp_len <= COMP_LEN_RST;
      cfg_r.max_comp_cnt <= COMP_CNT_RST;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_PATH_LEN: cfg_r.max_path_len <= cfg_wdata[PathLenW-1:0];
        REG_MAX_COMP_LEN: cfg_r.max_comp_len <= cfg_wdata[CompLimW-1:0];
        REG_MAX_COMP_CNT: cfg_r.max_comp_cnt <= cfg_wdata[CompCntW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/rpv_eval.sv]
module rpv_eval (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  rpv_pkg::item_t    item,
  input  rpv_pkg::cfg_t     cfg,
  output rpv_pkg::verdict_t verdict
);
  import rpv_pkg::*;

  logic [PathLenW-1:0] path_count_r;
  logic [CompLenW-1:0] comp_length_r;
  logic [CompCntW-1:0] comp_total_r;
  logic [ByteW-1:0]    first_char_r;
  logic [ByteW-1:0]    prev_char_r;
  logic                bad_byte_r;
  logic                bslash_r;
  logic                lead_slash_r;
  verdict_t            first_fault_r;

  logic [PathLenW-1:0] path_count_nxt;
  logic [CompLenW-1:0] comp_length_nxt;
  logic [CompCntW-1:0] comp_total_nxt;
  logic [ByteW-1:0]    first_char_nxt;
  logic [ByteW-1:0]    prev_char_nxt;
  logic                bad_byte_nxt;
  logic                bslash_nxt;
  logic                lead_slash_nxt;
  verdict_t            first_fault_nxt;

  logic                has_byte;
  logic                is_slash;
  logic                close;
  logic [PathLenW-1:0] len_lim;
  verdict_t            verdict_c;

  always_comb begin
    has_byte = !item.no_byte;
    is_slash = has_byte && (item.path_byte == CHAR_SLASH);

    path_count_nxt = path_count_r;
    if (has_byte && (path_count_r != PATH_COUNT_MAX)) begin
      path_count_nxt = path_count_r + 11'd1;
    end
    lead_slash_nxt = lead_slash_r || (is_slash && (path_count_r == '0));
    bslash_nxt = bslash_r || (has_byte && (item.path_byte == CHAR_BSLASH));

    comp_length_nxt = comp_length_r;
    first_char_nxt  = first_char_r;
    prev_char_nxt   = prev_char_r;
    bad_byte_nxt    = bad_byte_r;
    if (has_byte && !is_slash) begin
      if (comp_length_r == '0) begin
        first_char_nxt = item.path_byte;
      end
      if (comp_length_r != COMP_LEN_MAX) begin
        comp_length_nxt = comp_length_r + 9'd1;
      end
      prev_char_nxt = item.path_byte;
      if ((item.path_byte < BYTE_LOW) || (item.path_byte > BYTE_HIGH)) begin
        bad_byte_nxt = 1'b1;
      end
    end

    // close the open component on a slash or at the end of the path
    close = is_slash || (item.is_last && (comp_length_nxt != '0));

    comp_total_nxt  = comp_total_r;
    first_fault_nxt = first_fault_r;
    if (close && (first_fault_r == V_OK)) begin
      if (comp_length_nxt == '0) begin
        first_fault_nxt = V_EMPTY;
      end else if (comp_length_nxt > {1'b0, cfg.max_comp_len}) begin
        first_fault_nxt = V_LONG;
      end else if ((comp_length_nxt == 9'd1) && (first_char_nxt == CHAR_DOT)) begin
        first_fault_nxt = V_DOT;
      end else if ((comp_length_nxt == 9'd2) && (first_char_nxt == CHAR_DOT)
                   && (prev_char_nxt == CHAR_DOT)) begin
        first_fault_nxt = V_DOTDOT;
      end else if (first_char_nxt == CHAR_SPACE) begin
        first_fault_nxt = V_LEAD_SPACE;
      end else if ((prev_char_nxt == CHAR_SPACE) || (prev_char_nxt == CHAR_DOT)) begin
        first_fault_nxt = V_TRAIL;
      end else if (bad_byte_nxt) begin
        first_fault_nxt = V_BYTE;
      end else if (comp_total_r >= cfg.max_comp_cnt) begin
        first_fault_nxt = V_COUNT;
      end else begin
        comp_total_nxt = comp_total_r + 6'd1;
      end
    end

    len_lim = (cfg.max_path_len > PATH_LEN_CAP) ? PATH_LEN_CAP : cfg.max_path_len;
    if ((path_count_nxt == '0) || (path_count_nxt > len_lim)) begin
      verdict_c = V_LENGTH;
    end else if (lead_slash_nxt) begin
      verdict_c = V_ABSOLUTE;
    end else if (bslash_nxt) begin
      verdict_c = V_BACKSLASH;
    end else begin
      verdict_c = first_fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.is_last)) begin
      path_count_r  <= '0;
      comp_length_r <= '0;
      comp_total_r  <= '0;
      first_char_r  <= '0;
      prev_char_r   <= '0;
      bad_byte_r    <= 1'b0;
      bslash_r      <= 1'b0;
      lead_slash_r  <= 1'b0;
      first_fault_r <= V_OK;
    end else if (step) begin
      path_count_r  <= path_count_nxt;
      comp_total_r  <= comp_total_nxt;
      bslash_r      <= bslash_nxt;
      lead_slash_r  <= lead_slash_nxt;
      first_fault_r <= first_fault_nxt;
      if (close) begin
        comp_length_r <= '0;
        first_char_r  <= '0;
        prev_char_r   <= '0;
        bad_byte_r    <= 1'b0;
      end else begin
        comp_length_r <= comp_length_nxt;
        first_char_r  <= first_char_nxt;
        prev_char_r   <= prev_char_nxt;
        bad_byte_r    <= bad_byte_nxt;
      end
    end
  end

  assign verdict = verdict_c;

endmodule

[rtl/relative_path_validator_core.sv]
// Data path: a request carrying the last mark is held in the input register, and its
// verdict is then registered in the output register (input register, then result register).
// Throughput: one request per cycle; the path state updates in a single pass. A request
// with the last mark waits in the input register while the previous verdict is not taken.
// Reset: rst_n clears the path state and both valid flags and loads the limit
// registers with 1024, 255 and 32.
module relative_path_validator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // path_byte[7:0]
  input  logic                          in_tlast,
  input  logic                          in_tuser,   // no_byte[0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // verdict[3:0], zero[7:4]
  input  logic                          cfg_wen,
  input  logic [rpv_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [rpv_pkg::CfgDataW-1:0]  cfg_wdata
);
  import rpv_pkg::*;

  logic     in_valid_r;
  item_t    item_r;
  logic     out_valid_r;
  verdict_t out_verdict_r;
  logic     advance;
  cfg_t     cfg;
  verdict_t verdict;

  assign advance   = in_valid_r && (!item_r.is_last || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.path_byte <= in_tdata;
      item_r.is_last   <= in_tlast;
      item_r.no_byte   <= in_tuser;
    end
  end

  rpv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpv_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (item_r),
    .cfg     (cfg),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && item_r.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_r.is_last) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_verdict_r};

endmodule
